// ===== hw/rtl/svpwm_duty_from_dq_macros.svh =====
// Assertion macros for the SVPWM duty block.
// Used by svpwm_duty_from_dq; no other dependencies.
`ifndef SVPWM_DUTY_FROM_DQ_MACROS_SVH
`define SVPWM_DUTY_FROM_DQ_MACROS_SVH

// same-cycle implication
`define SVPWM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SVPWM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/svpwm_pkg.sv =====
// Shared constants for the SVPWM duty datapath: CORDIC table, defaults.
// No dependencies.
package svpwm_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int VOLT_BITS_DEF  = 16;
    localparam int DUTY_BITS      = 16;
    localparam int CORDIC_STEPS   = 16;
    localparam int CORDIC_W       = 34;

    localparam logic [DUTY_BITS-1:0] PERIOD_RST = 16'd4250;
    localparam logic signed [CORDIC_W-1:0] CORDIC_START = 34'sd652032874;
    localparam logic signed [18:0] SQRT3_Q16 = 19'sd113512;
    localparam logic signed [CORDIC_W-1:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [CORDIC_W-1:0] HALF_TURN = 34'sd2147483648;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic signed [CORDIC_W-1:0] atan_turn(input logic [3:0] idx);
        logic [31:0] v;
        unique case (idx)
            4'd0:  v = 32'h20000000;
            4'd1:  v = 32'h12E4051E;
            4'd2:  v = 32'h09FB385B;
            4'd3:  v = 32'h051111D4;
            4'd4:  v = 32'h028B0D43;
            4'd5:  v = 32'h0145D7E1;
            4'd6:  v = 32'h00A2F61E;
            4'd7:  v = 32'h00517C55;
            4'd8:  v = 32'h0028BE53;
            4'd9:  v = 32'h00145F2F;
            4'd10: v = 32'h000A2F98;
            4'd11: v = 32'h000517CC;
            4'd12: v = 32'h00028BE6;
            4'd13: v = 32'h000145F3;
            4'd14: v = 32'h0000A2FA;
            4'd15: v = 32'h0000517D;
            default: v = 32'h0;
        endcase
        return $signed({2'b00, v});
    endfunction

endpackage

// ===== hw/rtl/svpwm_duty_from_dq.sv =====
// SVPWM duty block top level: inverse Park/Clarke, min-max injection, scaling.
// Throughput: one item per cycle; the whole pipeline holds while the output
// register is full and not taken (17 CORDIC, 6 arithmetic, 17 divider stages).
// Reset (synchronous, active low) clears all valid bits and sets r_period to 4250.
`include "svpwm_duty_from_dq_macros.svh"
module svpwm_duty_from_dq #(
    parameter int ANGLE_BITS = svpwm_pkg::ANGLE_BITS_DEF,
    parameter int VOLT_BITS  = svpwm_pkg::VOLT_BITS_DEF,
    localparam int TDW = ((3*VOLT_BITS + ANGLE_BITS + 7) / 8) * 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [svpwm_pkg::DUTY_BITS-1:0] i_cfg_wr_data,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // volt_d, volt_q, angle, bus_volts (low bits up), zero padded
    input  logic [TDW-1:0]                i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // duty_u, duty_v, duty_w (low bits up)
    output logic [3*svpwm_pkg::DUTY_BITS-1:0] o_m_axis_tdata
);
    import svpwm_pkg::*;

    localparam int VB  = VOLT_BITS;
    localparam int CW  = CORDIC_W;
    localparam int PW1 = VB + CW;      // product width
    localparam int AW  = VB + 10;      // alpha / beta / h
    localparam int HW  = AW + 19;
    localparam int PW  = AW + 2;       // doubled phases
    localparam int EW  = AW + 4;
    localparam int SW  = AW + 5;
    localparam int NW  = VB + 11;      // n and full
    localparam int PRW = DUTY_BITS + NW;
    localparam int NS  = CORDIC_STEPS;

    logic [DUTY_BITS-1:0] r_period;
    logic en;

    assign en = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = en && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RST;
        end else if (i_cfg_wr_en) begin
            r_period <= i_cfg_wr_data;
        end
    end

    // ---------------- input fields and angle fold ----------------
    logic signed [VB-1:0] in_d, in_q;
    logic [ANGLE_BITS-1:0] in_ang;
    logic [VB-1:0] in_bus, bus_sat;
    logic [31:0] zu;
    logic signed [CW-1:0] z_raw, z_fold;
    logic flip;

    assign in_d   = $signed(i_s_axis_tdata[VB-1:0]);
    assign in_q   = $signed(i_s_axis_tdata[2*VB-1:VB]);
    assign in_ang = i_s_axis_tdata[2*VB+ANGLE_BITS-1:2*VB];
    assign in_bus = i_s_axis_tdata[3*VB+ANGLE_BITS-1:2*VB+ANGLE_BITS];
    assign bus_sat = (in_bus == '0) ? VB'(1) : in_bus;
    assign zu = {in_ang, {(32-ANGLE_BITS){1'b0}}};
    assign z_raw = CW'($signed(zu));

    always_comb begin
        flip = 1'b0;
        z_fold = z_raw;
        if (z_raw > QUARTER_TURN) begin
            z_fold = z_raw - HALF_TURN;
            flip = 1'b1;
        end else if (z_raw < -QUARTER_TURN) begin
            z_fold = z_raw + HALF_TURN;
            flip = 1'b1;
        end
    end

    // ---------------- CORDIC pipeline ----------------
    logic                 r_cv [0:NS];
    logic signed [CW-1:0] r_cx [0:NS];
    logic signed [CW-1:0] r_cy [0:NS];
    logic signed [CW-1:0] r_cz [0:NS];
    logic signed [VB-1:0] r_cd [0:NS];
    logic signed [VB-1:0] r_cq [0:NS];
    logic [VB-1:0]        r_cb [0:NS];
    logic                 r_cf [0:NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv[0] <= 1'b0;
        end else if (en) begin
            r_cv[0] <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cx[0] <= CORDIC_START;
            r_cy[0] <= '0;
            r_cz[0] <= z_fold;
            r_cd[0] <= in_d;
            r_cq[0] <= in_q;
            r_cb[0] <= bus_sat;
            r_cf[0] <= flip;
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_cordic
        logic signed [CW-1:0] ys, xs;
        assign ys = r_cy[i] >>> i;
        assign xs = r_cx[i] >>> i;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cv[i+1] <= 1'b0;
            end else if (en) begin
                r_cv[i+1] <= r_cv[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                if (r_cz[i] >= 0) begin
                    r_cx[i+1] <= r_cx[i] - ys;
                    r_cy[i+1] <= r_cy[i] + xs;
                    r_cz[i+1] <= r_cz[i] - atan_turn(4'(i));
                end else begin
                    r_cx[i+1] <= r_cx[i] + ys;
                    r_cy[i+1] <= r_cy[i] - xs;
                    r_cz[i+1] <= r_cz[i] + atan_turn(4'(i));
                end
                r_cd[i+1] <= r_cd[i];
                r_cq[i+1] <= r_cq[i];
                r_cb[i+1] <= r_cb[i];
                r_cf[i+1] <= r_cf[i];
            end
        end
    end

    // ---------------- Park / Clarke / injection ----------------
    logic signed [CW-1:0] cos_v, sin_v;
    assign cos_v = r_cf[NS] ? -r_cx[NS] : r_cx[NS];
    assign sin_v = r_cf[NS] ? -r_cy[NS] : r_cy[NS];

    logic r_mv [1:6];
    logic [VB-1:0] r_mb [1:6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= 6; k++) r_mv[k] <= 1'b0;
        end else if (en) begin
            r_mv[1] <= r_cv[NS];
            for (int k = 2; k <= 6; k++) r_mv[k] <= r_mv[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mb[1] <= r_cb[NS];
            for (int k = 2; k <= 6; k++) r_mb[k] <= r_mb[k-1];
        end
    end

    logic signed [PW1-1:0] r_p_dc, r_p_qs, r_p_ds, r_p_qc;
    logic signed [AW-1:0]  r_alpha, r_beta, r_alpha3, r_h;
    logic signed [PW-1:0]  r_u2, r_v2, r_w2, r_u5, r_v5, r_w5;
    logic signed [PW:0]    r_mid;
    logic signed [PW-1:0]  hi, lo;
    logic [NW-1:0]         r_n [0:2];

    always_comb begin
        hi = r_u2;
        if (r_v2 > hi) hi = r_v2;
        if (r_w2 > hi) hi = r_w2;
        lo = r_u2;
        if (r_v2 < lo) lo = r_v2;
        if (r_w2 < lo) lo = r_w2;
    end

    logic signed [PW-1:0] ph5 [0:2];
    logic signed [EW-1:0] e6 [0:2];
    logic signed [SW-1:0] nn [0:2];
    logic [NW-1:0] full6;
    assign ph5[0] = r_u5;
    assign ph5[1] = r_v5;
    assign ph5[2] = r_w5;
    assign full6 = NW'(r_mb[5]) << 10;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            e6[k] = (EW'(ph5[k]) <<< 1) - EW'(r_mid);
            nn[k] = ($signed(SW'(r_mb[5])) <<< 9) + SW'(e6[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_dc <= PW1'(r_cd[NS]) * PW1'(cos_v);
            r_p_qs <= PW1'(r_cq[NS]) * PW1'(sin_v);
            r_p_ds <= PW1'(r_cd[NS]) * PW1'(sin_v);
            r_p_qc <= PW1'(r_cq[NS]) * PW1'(cos_v);

            r_alpha <= AW'((r_p_dc - r_p_qs) >>> 22);
            r_beta  <= AW'((r_p_ds + r_p_qc) >>> 22);

            r_alpha3 <= r_alpha;
            r_h <= AW'((HW'(r_beta) * HW'(SQRT3_Q16)) >>> 16);

            r_u2 <= PW'(r_alpha3) <<< 1;
            r_v2 <= PW'(r_h) - PW'(r_alpha3);
            r_w2 <= -PW'(r_alpha3) - PW'(r_h);

            r_u5  <= r_u2;
            r_v5  <= r_v2;
            r_w5  <= r_w2;
            r_mid <= (PW+1)'(hi) + (PW+1)'(lo);

            for (int k = 0; k < 3; k++) begin
                if (nn[k] < 0) begin
                    r_n[k] <= '0;
                end else if (nn[k] > $signed(SW'(full6))) begin
                    r_n[k] <= full6;
                end else begin
                    r_n[k] <= NW'(nn[k]);
                end
            end
        end
    end

    // ---------------- scale and restoring divide, one quotient bit a stage ----------------
    logic                 r_dv   [0:DUTY_BITS];
    logic [PRW-1:0]       r_rem  [0:DUTY_BITS][0:2];
    logic [NW-1:0]        r_full [0:DUTY_BITS];
    logic [DUTY_BITS-1:0] r_quo  [0:DUTY_BITS][0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (en) begin
            r_dv[0] <= r_mv[6];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_full[0] <= NW'(r_mb[6]) << 10;
            for (int k = 0; k < 3; k++) begin
                r_rem[0][k] <= PRW'(r_period) * PRW'(r_n[k]);
                r_quo[0][k] <= '0;
            end
        end
    end

    for (genvar s = 0; s < DUTY_BITS; s++) begin : g_div
        localparam int B = DUTY_BITS - 1 - s;
        logic [PRW-1:0] dsh;
        assign dsh = PRW'(r_full[s]) << B;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[s+1] <= 1'b0;
            end else if (en) begin
                r_dv[s+1] <= r_dv[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_full[s+1] <= r_full[s];
                for (int k = 0; k < 3; k++) begin
                    if (r_rem[s][k] >= dsh) begin
                        r_rem[s+1][k] <= r_rem[s][k] - dsh;
                        r_quo[s+1][k] <= r_quo[s][k] | (DUTY_BITS'(1) << B);
                    end else begin
                        r_rem[s+1][k] <= r_rem[s][k];
                        r_quo[s+1][k] <= r_quo[s][k];
                    end
                end
            end
        end
    end

    assign o_m_axis_tvalid = r_dv[DUTY_BITS];
    assign o_m_axis_tdata  = {r_quo[DUTY_BITS][2], r_quo[DUTY_BITS][1],
                              r_quo[DUTY_BITS][0]};

    // ---------------- checks ----------------
    `SVPWM_ASSERT_NOW(a_duty_le_period, o_m_axis_tvalid,
        (r_quo[DUTY_BITS][0] <= r_period) && (r_quo[DUTY_BITS][1] <= r_period)
        && (r_quo[DUTY_BITS][2] <= r_period), "duty above period")
    `SVPWM_ASSERT_NOW(a_stall_blocks_input, o_m_axis_tvalid && !i_m_axis_tready,
        !o_s_axis_tready, "input taken while output stalled")
    `SVPWM_ASSERT_NOW(a_n_in_range, r_dv[0],
        (r_rem[0][0] <= PRW'(r_period) * PRW'(r_full[0])), "scaled duty above full")
    `SVPWM_ASSERT_NEXT(a_valid_moves, en && r_cv[NS], r_mv[1], "valid lost after CORDIC")

endmodule

// ===== tb/svpwm_duty_from_dq_tb.sv =====
// Testbench for svpwm_duty_from_dq: drives d/q commands, angle and bus voltage,
// predicts the three compare counts in fixed point and checks every result item.
// Depends on svpwm_pkg and the svpwm_duty_from_dq RTL.
module svpwm_duty_from_dq_tb;

    localparam int IN_W  = 64;
    localparam int OUT_W = 3 * svpwm_pkg::DUTY_BITS;
    localparam int WATCHDOG_MAX = 20000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic [15:0] bus_volts;
        logic [15:0] angle;
        logic signed [15:0] volt_q;
        logic signed [15:0] volt_d;
    } cmd_t;

    typedef struct packed {
        logic [15:0] duty_w;
        logic [15:0] duty_v;
        logic [15:0] duty_u;
    } duty_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_wr_en = 1'b0;
    logic [15:0]       i_cfg_wr_data = '0;
    logic              i_s_axis_tvalid = 1'b0;
    logic              o_s_axis_tready;
    logic [IN_W-1:0]   i_s_axis_tdata = '0;
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  o_m_axis_tdata;

    svpwm_duty_from_dq DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(i_s_axis_tdata),   // volt_d, volt_q, angle, bus_volts
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata(o_m_axis_tdata)    // duty_u, duty_v, duty_w
    );

    always #6 i_clk = ~i_clk;

    logic [15:0] period_reg = svpwm_pkg::PERIOD_RST;
    duty_t       expected_duties[$];
    int          mismatch_cnt = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          quiet_cycles = 0;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic void sine_cosine(input logic [15:0] ang,
                                        output longint s_out, output longint c_out);
        longint z, x, y, nx;
        bit     flip;
        z = longint'(ang) << 16;
        x = svpwm_pkg::CORDIC_START;
        y = 0;
        flip = 0;
        if (z >= 64'sd2147483648) z -= 64'sd4294967296;
        if (z > 64'sd1073741824) begin
            z -= 64'sd2147483648;
            flip = 1;
        end else if (z < -64'sd1073741824) begin
            z += 64'sd2147483648;
            flip = 1;
        end
        for (int i = 0; i < 16; i++) begin
            longint at;
            at = longint'(svpwm_pkg::atan_turn(i[3:0]));
            if (z >= 0) begin
                nx = x - floor_shift(y, i);
                y  = y + floor_shift(x, i);
                z -= at;
            end else begin
                nx = x + floor_shift(y, i);
                y  = y - floor_shift(x, i);
                z += at;
            end
            x = nx;
        end
        c_out = flip ? -x : x;
        s_out = flip ? -y : y;
    endfunction

    function automatic logic [15:0] phase_count(longint e, longint bus);
        longint full, n;
        full = bus * 1024;
        n = bus * 512 + e;
        if (n < 0) n = 0;
        if (n > full) n = full;
        return 16'((longint'(period_reg) * n) / full);
    endfunction

    function automatic duty_t predict_duties(cmd_t c);
        longint vd, vq, bus, sn, cs, alpha, beta, h, u2, v2, w2, hi, lo, mid;
        duty_t  r;
        vd = longint'(c.volt_d);
        vq = longint'(c.volt_q);
        bus = (c.bus_volts == 0) ? 1 : longint'(c.bus_volts);
        sine_cosine(c.angle, sn, cs);
        alpha = floor_shift(vd * cs - vq * sn, 22);
        beta  = floor_shift(vd * sn + vq * cs, 22);
        h = floor_shift(beta * 113512, 16);
        u2 = 2 * alpha;
        v2 = -alpha + h;
        w2 = -alpha - h;
        hi = u2; if (v2 > hi) hi = v2; if (w2 > hi) hi = w2;
        lo = u2; if (v2 < lo) lo = v2; if (w2 < lo) lo = w2;
        mid = hi + lo;
        r.duty_u = phase_count(2 * u2 - mid, bus);
        r.duty_v = phase_count(2 * v2 - mid, bus);
        r.duty_w = phase_count(2 * w2 - mid, bus);
        return r;
    endfunction

    // receiver stall and result checking
    always @(negedge i_clk) begin
        if (i_rst_n)
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            duty_t got, want;
            got = o_m_axis_tdata;
            if (expected_duties.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                mismatch_cnt++;
            end else begin
                want = expected_duties.pop_front();
                if (got.duty_u !== want.duty_u)
                    $display("%0t: duty_u exp %0d got %0d", $time, want.duty_u, got.duty_u);
                if (got.duty_v !== want.duty_v)
                    $display("%0t: duty_v exp %0d got %0d", $time, want.duty_v, got.duty_v);
                if (got.duty_w !== want.duty_w)
                    $display("%0t: duty_w exp %0d got %0d", $time, want.duty_w, got.duty_w);
                if (got !== want) mismatch_cnt++;
            end
        end
    end

    // watchdog on cycles without any accepted item
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // tvalid stays high on return; the next call or wait_drained drives it
    task automatic send_cmd(cmd_t c);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= c;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        expected_duties.push_back(predict_duties(c));
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (expected_duties.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_period(logic [15:0] p);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= p;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        period_reg = p;
    endtask

    function automatic cmd_t make_cmd(int d, int q, int a, int b);
        cmd_t c;
        c.volt_d = 16'(d);
        c.volt_q = 16'(q);
        c.angle = 16'(a);
        c.bus_volts = 16'(b);
        return c;
    endfunction

    function automatic cmd_t random_cmd();
        cmd_t c;
        int   b;
        c = {$urandom, $urandom};
        // mostly sensible commands against a bus, some raw noise
        if ($urandom_range(3) != 0) begin
            b = $urandom_range(65535, 1);
            c.bus_volts = 16'(b);
            c.volt_d = 16'($signed($urandom_range(2 * (b / 2), 0)) - b / 2);
            c.volt_q = 16'($signed($urandom_range(2 * (b / 2), 0)) - b / 2);
        end
        return c;
    endfunction

    task automatic test_directed();
        send_cmd(make_cmd(0, 0, 0, 12288));
        send_cmd(make_cmd(32767, 32767, 16'hFFFF, 65535));
        send_cmd(make_cmd(-32768, -32768, 16'h8000, 65535));
        send_cmd(make_cmd(3000, 0, 16'h4000, 0));          // zero bus
        send_cmd(make_cmd(-3000, 2000, 16'hC000, 0));
        send_cmd(make_cmd(32767, -32768, 16'h4001, 1));     // hard clamp
        send_cmd(make_cmd(-32768, 32767, 16'hBFFF, 1));
        send_cmd(make_cmd(4000, 4000, 16'h2000, 12288));
        send_cmd(make_cmd(0, 6000, 16'h6000, 12288));
        send_cmd(make_cmd(6000, 0, 16'hA000, 12288));
        send_cmd(make_cmd(0, -6000, 16'hE000, 12288));
        send_cmd(make_cmd(100, -100, 16'h0001, 256));
        send_cmd(make_cmd(20000, 20000, 16'h7FFF, 16384));
    endtask

    task automatic test_period_extremes();
        write_period(16'd0);
        for (int i = 0; i < 4; i++) send_cmd(random_cmd());
        write_period(16'd1);
        for (int i = 0; i < 4; i++) send_cmd(random_cmd());
        write_period(16'hFFFF);
        send_cmd(make_cmd(32767, 32767, 16'h1234, 65535));
        send_cmd(make_cmd(-32768, 0, 16'h0000, 1));
        for (int i = 0; i < 4; i++) send_cmd(random_cmd());
    endtask

    task automatic test_random(int n, int s_pct, int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int i = 0; i < n; i++) begin
            if (i == n / 2) wait_drained();
            send_cmd(random_cmd());
        end
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        send_idle_pct = 21;
        recv_idle_pct = 46;
        test_directed();
        test_period_extremes();
        write_period(16'd4250);
        test_random(330, 21, 46);
        write_period(16'($urandom_range(65535, 1)));
        test_random(330, 46, 21);
        write_period(16'd999);
        test_random(340, 0, 0);
        wait_drained();
        if (mismatch_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== svpwm_duty_from_dq.f =====
+incdir+hw/rtl
hw/rtl/svpwm_pkg.sv
hw/rtl/svpwm_duty_from_dq.sv
tb/svpwm_duty_from_dq_tb.sv
